// ----- hw/rtl/cdlba_pkg.sv -----
// Shared constants and stage payload types for the CD position converter.
// No dependencies.
package cdlba_pkg;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam logic signed [19:0] LBA_MIN   = -20'sd150;
    localparam logic signed [19:0] LBA_MAX   = 20'sd449849;
    localparam logic signed [20:0] LEAD_IN   = 21'sd150;
    localparam logic [18:0]        POS_MAX   = 19'd449999;

    // reciprocal multipliers: exact over the position and second ranges
    localparam logic [18:0] RECIP_75 = 19'd447393;
    localparam int          SHIFT_75 = 25;
    localparam logic [13:0] RECIP_60 = 14'd8739;
    localparam int          SHIFT_60 = 19;

    localparam logic [18:0] SECT_PER_SEC = 19'd75;
    localparam logic [12:0] SEC_PER_MIN  = 13'd60;

    typedef enum logic {
        KIND_TO_MSF = 1'b0,
        KIND_TO_LBA = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [18:0] pos;
        logic [7:0]  mi;
        logic [7:0]  se;
        logic [7:0]  sc;
    } prep_t;

    typedef struct packed {
        kind_t              kind;
        logic [6:0]         minute;
        logic [5:0]         second;
        logic [6:0]         sector;
        logic signed [20:0] lba;
    } split_t;

endpackage

// ----- hw/rtl/cdlba_prep.sv -----
// First stage: clamp and lead-in offset of the block number, BCD byte decode.
// Depends on cdlba_pkg.
module cdlba_prep (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  cdlba_pkg::kind_t     in_kind,
    input  logic signed [19:0]   in_lba,
    input  logic [7:0]           in_minute_bcd,
    input  logic [7:0]           in_second_bcd,
    input  logic [7:0]           in_sector_bcd,
    output logic                 out_valid,
    output cdlba_pkg::prep_t     out_data
);
    import cdlba_pkg::*;

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    logic               valid_reg;
    prep_t              data_reg;
    prep_t              data_next;
    logic signed [20:0] sum;

    always_comb begin
        sum            = {in_lba[19], in_lba} + LEAD_IN;
        data_next.kind = in_kind;
        if (in_lba < LBA_MIN) begin
            data_next.pos = '0;
        end else if (in_lba > LBA_MAX) begin
            data_next.pos = POS_MAX;
        end else begin
            data_next.pos = sum[18:0];
        end
        data_next.mi = from_bcd(in_minute_bcd);
        data_next.se = from_bcd(in_second_bcd);
        data_next.sc = from_bcd(in_sector_bcd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ----- hw/rtl/cdlba_split.sv -----
// Stages two to four: split position into minute/second/sector by reciprocal
// multiplies, and recombine decoded parts into a block number.
// Depends on cdlba_pkg.
module cdlba_split (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cdlba_pkg::prep_t  in_data,
    output logic              out_valid,
    output cdlba_pkg::split_t out_data
);
    import cdlba_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [18:0] pos;
        logic [12:0] q;
        logic [13:0] t1;
        logic [7:0]  sc;
    } s2_t;

    typedef struct packed {
        kind_t              kind;
        logic [12:0]        q;
        logic [6:0]         minute;
        logic [6:0]         sector;
        logic signed [20:0] lba;
    } s3_t;

    logic [2:0] valid_reg;
    s2_t        s2_reg;
    s2_t        s2_next;
    s3_t        s3_reg;
    s3_t        s3_next;
    split_t     s4_reg;
    split_t     s4_next;

    logic [37:0] prod75;
    logic [26:0] prod60;
    logic [18:0] whole75;
    logic [18:0] rem75;
    logic [20:0] sum_lba;
    logic [12:0] whole60;

    always_comb begin
        prod75       = {19'd0, in_data.pos} * {19'd0, RECIP_75};
        s2_next.kind = in_data.kind;
        s2_next.pos  = in_data.pos;
        s2_next.q    = prod75[SHIFT_75 +: 13];
        s2_next.t1   = 14'({6'd0, in_data.mi} * 14'd60) + {6'd0, in_data.se};
        s2_next.sc   = in_data.sc;
    end

    always_comb begin
        prod60         = {14'd0, s2_reg.q} * {13'd0, RECIP_60};
        whole75        = 19'({6'd0, s2_reg.q} * SECT_PER_SEC);
        rem75          = s2_reg.pos - whole75;
        sum_lba        = 21'({7'd0, s2_reg.t1} * 21'd75) + {13'd0, s2_reg.sc};
        s3_next.kind   = s2_reg.kind;
        s3_next.q      = s2_reg.q;
        s3_next.minute = prod60[SHIFT_60 +: 7];
        s3_next.sector = rem75[6:0];
        s3_next.lba    = $signed(sum_lba) - LEAD_IN;
    end

    always_comb begin
        whole60        = 13'({6'd0, s3_reg.minute} * SEC_PER_MIN);
        s4_next.kind   = s3_reg.kind;
        s4_next.minute = s3_reg.minute;
        s4_next.second = 6'(s3_reg.q - whole60);
        s4_next.sector = s3_reg.sector;
        s4_next.lba    = s3_reg.lba;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = s4_reg;
endmodule

// ----- hw/rtl/cdlba_pack.sv -----
// Final stage: BCD encode of the split parts and output beat register.
// Depends on cdlba_pkg.
module cdlba_pack (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  cdlba_pkg::split_t                  in_data,
    output logic                               m_tvalid,
    output logic [cdlba_pkg::M_DATA_W-1:0]     m_tdata
);
    import cdlba_pkg::*;

    // x < 100: tens by x*205 >> 11
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  u;
        p = {8'd0, v} * 15'd205;
        t = p[14:11];
        u = v - 7'({3'd0, t} * 7'd10);
        return {t, u[3:0]};
    endfunction

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;
    logic [M_DATA_W-1:0] data_next;
    logic [7:0]          min_bcd;
    logic [7:0]          sec_bcd;
    logic [7:0]          sct_bcd;

    always_comb begin
        min_bcd   = to_bcd(in_data.minute);
        sec_bcd   = to_bcd({1'b0, in_data.second});
        sct_bcd   = to_bcd(in_data.sector);
        data_next = '0;
        if (in_data.kind == KIND_TO_MSF) begin
            data_next[7:0]   = min_bcd;
            data_next[14:8]  = sec_bcd[6:0];
            data_next[21:15] = sct_bcd[6:0];
        end else begin
            data_next[42:22] = in_data.lba;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
endmodule

// ----- hw/rtl/cd_lba_msf_bcd_converter_core.sv -----
// CD position converter, block number <-> packed BCD minute/second/sector.
// Registers in order: prep, split s2/s3/s4, pack; m_tvalid is the pack valid register.
// One beat per cycle sustained while the result beat is taken or the output register is empty.
// All five stages advance together whenever the output register is free or taken,
// so throughput is set by that shared stage advance.
// Reset (aresetn low, synchronous) clears every stage valid bit; no other state.
// Depends on cdlba_pkg, cdlba_prep, cdlba_split, cdlba_pack.
module cd_lba_msf_bcd_converter_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [19:0] in_lba, [27:20] in_minute_bcd, [35:28] in_second_bcd,
    // [43:36] in_sector_bcd, [47:44] zero
    input  logic [cdlba_pkg::S_DATA_W-1:0] s_tdata,
    // [0] kind
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_minute_bcd, [14:8] out_second_bcd, [21:15] out_sector_bcd,
    // [42:22] out_lba, [47:43] zero
    output logic [cdlba_pkg::M_DATA_W-1:0] m_tdata
);
    import cdlba_pkg::*;

    logic   en;
    logic   prep_valid;
    prep_t  prep_data;
    logic   split_valid;
    split_t split_data;
    kind_t  in_kind;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign in_kind  = kind_t'(s_tuser[0]);

    cdlba_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .in_kind       (in_kind),
        .in_lba        ($signed(s_tdata[19:0])),
        .in_minute_bcd (s_tdata[27:20]),
        .in_second_bcd (s_tdata[35:28]),
        .in_sector_bcd (s_tdata[43:36]),
        .out_valid     (prep_valid),
        .out_data      (prep_data)
    );

    cdlba_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (split_valid),
        .out_data  (split_data)
    );

    cdlba_pack u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (split_valid),
        .in_data  (split_data),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // only one kind of result is ever populated
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42:22] == 21'd0) || (m_tdata[21:0] == 22'd0))
        else $error("both result kinds populated");

    // every BCD digit but the sector tens is decimal, second tens below six
    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= 4'd9) && (m_tdata[7:4] <= 4'd9) &&
                     (m_tdata[11:8] <= 4'd9) && (m_tdata[14:12] <= 3'd5) &&
                     (m_tdata[18:15] <= 4'd9))
        else $error("non-decimal BCD digit in result");

    // padding stays clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:43] == 5'd0))
        else $error("result padding not zero");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the CD position converter: block number <-> BCD MSF.
// Holds a scoreboard class with its own position predictor; needs cdlba_pkg and
// cd_lba_msf_bcd_converter_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAD_IN_SECTORS = 150;
    localparam int SECTORS_PER_SEC = 75;
    localparam int SECONDS_PER_MIN = 60;
    localparam int LBA_FLOOR       = -150;
    localparam int LBA_CEILING     = 449849;
    localparam int RANDOM_ITEMS    = 550;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 12;

    typedef struct packed {
        logic [4:0]         pad;
        logic signed [20:0] lba;
        logic [6:0]         sector;
        logic [6:0]         second;
        logic [7:0]         minute;
    } position_t;

    class msf_lba_scoreboard;
        position_t pending_positions[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        static function logic [7:0] bcd_pack(int n);
            return 8'(((n / 10) << 4) + (n % 10));
        endfunction

        static function int bcd_value(logic [7:0] b);
            return int'(b[7:4]) * 10 + int'(b[3:0]);
        endfunction

        static function position_t predict_position(cdlba_pkg::kind_t k,
                                                    logic [47:0] d);
            position_t          r;
            logic signed [19:0] lba_in;
            int                 lba;
            int                 pos;
            logic [7:0]         b;
            r = '0;
            if (k == cdlba_pkg::KIND_TO_MSF) begin
                lba_in = d[19:0];
                lba = lba_in;
                if (lba < LBA_FLOOR) lba = LBA_FLOOR;
                if (lba > LBA_CEILING) lba = LBA_CEILING;
                pos = lba + LEAD_IN_SECTORS;
                r.minute = bcd_pack(pos / SECTORS_PER_SEC / SECONDS_PER_MIN);
                b = bcd_pack((pos / SECTORS_PER_SEC) % SECONDS_PER_MIN);
                r.second = b[6:0];
                b = bcd_pack(pos % SECTORS_PER_SEC);
                r.sector = b[6:0];
            end else begin
                lba = (bcd_value(d[27:20]) * SECONDS_PER_MIN + bcd_value(d[35:28]))
                      * SECTORS_PER_SEC + bcd_value(d[43:36]) - LEAD_IN_SECTORS;
                r.lba = 21'(lba);
            end
            return r;
        endfunction

        function void note_input(cdlba_pkg::kind_t k, logic [47:0] d);
            pending_positions.push_back(predict_position(k, d));
        endfunction

        function int pending();
            return pending_positions.size();
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [47:0] d);
            position_t exp_p;
            position_t act_p;
            act_p = d;
            if (pending_positions.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, d);
                errors++;
            end else begin
                exp_p = pending_positions.pop_front();
                compare_field("minute", 32'(exp_p.minute), 32'(act_p.minute));
                compare_field("second", 32'(exp_p.second), 32'(act_p.second));
                compare_field("sector", 32'(exp_p.sector), 32'(act_p.sector));
                compare_field("lba", 32'(unsigned'(exp_p.lba)), 32'(unsigned'(act_p.lba)));
                compare_field("pad", 32'(exp_p.pad), 32'(act_p.pad));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    msf_lba_scoreboard sb = new();

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cd_lba_msf_bcd_converter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [47:0] lba_word(int lba, bit noise);
        logic [47:0] d;
        d = '0;
        d[19:0] = lba[19:0];
        if (noise) d[43:20] = 24'($urandom);
        return d;
    endfunction

    function automatic logic [47:0] bcd_word(logic [7:0] mi, logic [7:0] se,
                                             logic [7:0] sc, bit noise);
        logic [47:0] d;
        d = '0;
        d[27:20] = mi;
        d[35:28] = se;
        d[43:36] = sc;
        if (noise) d[19:0] = 20'($urandom);
        return d;
    endfunction

    function automatic logic [7:0] random_bcd(int tens_max);
        return {4'($urandom_range(0, tens_max)), 4'($urandom_range(0, 9))};
    endfunction

    // one beat on the input side; entered and left just after a rising edge
    task automatic send_beat(cdlba_pkg::kind_t k, logic [47:0] d);
        int gap;
        bit took;
        gap = tx_no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= k;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        sb.note_input(k, d);
    endtask

    task automatic send_random();
        cdlba_pkg::kind_t k;
        int               sel;
        int               lba;
        k = cdlba_pkg::kind_t'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        if (k == cdlba_pkg::KIND_TO_MSF) begin
            if (sel < 7)
                lba = int'($urandom_range(0, 450000)) - LEAD_IN_SECTORS;
            else if (sel < 9)
                lba = ((sel == 7) ? LBA_FLOOR : LBA_CEILING) - 4 + int'($urandom_range(0, 8));
            else
                lba = int'($urandom);
            send_beat(k, lba_word(lba, 1'b1));
        end else begin
            if (sel < 8)
                send_beat(k, bcd_word(random_bcd(9), random_bcd(5), random_bcd(7), 1'b1));
            else
                send_beat(k, bcd_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1));
        end
    endtask

    // result side, with its own stalls and the one long hold-off
    initial begin
        int          stall;
        bit          took;
        logic [47:0] beat;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            stall = rx_no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                took = m_tvalid;
                beat = m_tdata;
                @(posedge aclk);
            end while (!took);
            sb.check_result(beat);
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lead-in edge, second/minute roll-overs, saturation both ways
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(-150, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(0, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(-76, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(-75, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(4349, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(4350, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(449849, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(449850, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(524287, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(-151, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(-524288, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_MSF, lba_word(123456, 1'b1));
        // BCD side: zero, origin, top decimal, non-decimal nibbles
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'h00, 8'h00, 8'h00, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'h00, 8'h02, 8'h00, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'h00, 8'h00, 8'h01, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'h99, 8'h59, 8'h74, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'h99, 8'h99, 8'h99, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'hA5, 8'h5A, 8'hC3, 1'b0));
        send_beat(cdlba_pkg::KIND_TO_LBA, bcd_word(8'h12, 8'h34, 8'h56, 1'b1));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 110 == 0) begin
                tx_no_idle = ($urandom_range(0, 2) == 0);
                rx_no_idle = ($urandom_range(0, 2) == 0);
            end
            if (i == 200) begin
                tx_no_idle = 1'b1;
                hold_req = 1'b1;
            end
            if (i == 380) begin
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cdlba_pkg.sv
hw/rtl/cdlba_prep.sv
hw/rtl/cdlba_split.sv
hw/rtl/cdlba_pack.sv
hw/rtl/cd_lba_msf_bcd_converter_core.sv
tb/sv/tb_top.sv
